@@ rtl/sha512_hash_engine_assert.svh @@
// ----------------------------------------------------------------------------
// SHA-512 hash engine assertion macros
// Shared concurrent assertion forms used by the engine modules.
// ----------------------------------------------------------------------------
`ifndef SHA512_HASH_ENGINE_ASSERT_SVH
`define SHA512_HASH_ENGINE_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define SHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SHA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/sha512_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 package
// Word types, initial hash values and round constants.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned RoundW  = 7;

  typedef logic [WordW-1:0]       word_t;
  typedef logic [15:0][WordW-1:0] blk_t;
  typedef logic [7:0][WordW-1:0]  hash_t;

  function automatic hash_t h_init();
    hash_t h;
    h[0] = 64'h6a09e667f3bcc908;
    h[1] = 64'hbb67ae8584caa73b;
    h[2] = 64'h3c6ef372fe94f82b;
    h[3] = 64'ha54ff53a5f1d36f1;
    h[4] = 64'h510e527fade682d1;
    h[5] = 64'h9b05688c2b3e6c1f;
    h[6] = 64'h1f83d9abfb41bd6b;
    h[7] = 64'h5be0cd19137e2179;
    return h;
  endfunction

  function automatic word_t round_k(input logic [RoundW-1:0] t);
    word_t k;
    case (t)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/sha512_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 compression core
// Runs the 80 rounds of one block, one round per cycle, with a rolling
// sixteen-word message schedule.
// ----------------------------------------------------------------------------
`include "sha512_hash_engine_assert.svh"

module sha512_core import sha512_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  blk_t  blk_i,
  input  hash_t hash_i,
  output logic  done_o,
  output hash_t vars_o
);

  logic [RoundW-1:0] rnd_q;
  logic              busy_q;
  logic              done_q;
  blk_t              sched_q;
  hash_t             vars_q;

  word_t big0, big1, ch, maj, t1, sig0, sig1, w_new;
  word_t a, e;

  always_comb begin
    a     = vars_q[0];
    e     = vars_q[4];
    big1  = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
    ch    = (e & vars_q[5]) ^ (~e & vars_q[6]);
    t1    = vars_q[7] + big1 + ch + round_k(rnd_q) + sched_q[0];
    big0  = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
    maj   = (a & vars_q[1]) ^ (a & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
    sig0  = {sched_q[1][0], sched_q[1][63:1]} ^ {sched_q[1][7:0], sched_q[1][63:8]} ^
            (sched_q[1] >> 7);
    sig1  = {sched_q[14][18:0], sched_q[14][63:19]} ^
            {sched_q[14][60:0], sched_q[14][63:61]} ^ (sched_q[14] >> 6);
    w_new = sig1 + sched_q[9] + sig0 + sched_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == RoundW'(Rounds - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sched_q <= blk_i;
      vars_q  <= hash_i;
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= w_new;
      vars_q[7]   <= vars_q[6];
      vars_q[6]   <= vars_q[5];
      vars_q[5]   <= vars_q[4];
      vars_q[4]   <= vars_q[3] + t1;
      vars_q[3]   <= vars_q[2];
      vars_q[2]   <= vars_q[1];
      vars_q[1]   <= vars_q[0];
      vars_q[0]   <= t1 + big0 + maj;
    end
  end

  assign done_o = done_q;
  assign vars_o = vars_q;

  `SHA_NEVER(a_rnd_range, busy_q && rnd_q >= RoundW'(Rounds), "round count out of range")
  `SHA_NEVER(a_done_busy, done_q && busy_q, "done while still running")
  `SHA_ASSERT(a_done_end, done_q |-> $past(rnd_q) == RoundW'(Rounds - 1), "early done")

endmodule

@@ rtl/sha512_hash_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Packs message bytes into 128-byte blocks, compresses them and emits the
// eight digest words after padding the final block.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: message_word, valid_bytes; tlast: last_word
//  m_axis    out        tdata: digest_word; tlast: digest_last
//
//  A word is accepted, packed in up to two steps and then checked. A full
//  block is compressed in the shared round unit, which runs one round per
//  cycle. The last word adds a padding step and one or two blocks, then
//  eight output beats. Input is ready only in the idle state.
//  Reset loads the initial hash values and clears the byte count.
// ----------------------------------------------------------------------------
`include "sha512_hash_engine_assert.svh"

module sha512_hash_engine import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [63:0] message_word, [67:64] valid_bytes
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] digest_word
  output logic        m_axis_tlast_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ABSORB = 6'b000010,
    ST_PAD    = 6'b000100,
    ST_LOAD   = 6'b001000,
    ST_WAIT   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e        state_q;
  logic [127:0]  cnt_q;
  word_t         pend_q;
  logic [3:0]    pend_n_q;
  logic          last_q;
  logic          fin_q, extra_q, len_en_q;
  logic [4:0]    zero_from_q;
  logic [2:0]    out_idx_q;
  hash_t         hash_q;
  word_t         blk_q [16];

  logic          core_start, core_done;
  blk_t          load_blk;
  hash_t         core_vars;

  logic [3:0]    wi;
  logic [2:0]    off;
  logic [3:0]    room, n1;
  logic [6:0]    pos_next;
  logic [127:0]  len_bits;
  word_t         wmask, wdata, keep;
  logic          in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    wi       = cnt_q[6:3];
    off      = cnt_q[2:0];
    room     = 4'd8 - {1'b0, off};
    n1       = (pend_n_q < room) ? pend_n_q : room;
    pos_next = cnt_q[6:0] + {3'b000, n1};
    wmask    = ({64{1'b1}} >> {off, 3'b000}) &
               ~({64{1'b1}} >> {({1'b0, off} + n1), 3'b000});
    wdata    = pend_q >> {off, 3'b000};
    keep     = ~({64{1'b1}} >> {off, 3'b000});
    len_bits = {cnt_q[124:0], 3'b000};
    for (int i = 0; i < 16; i++) begin
      load_blk[i] = (5'(i) >= zero_from_q) ? '0 : blk_q[i];
    end
    if (len_en_q) begin
      load_blk[14] = len_bits[127:64];
      load_blk[15] = len_bits[63:0];
    end
  end

  assign core_start = (state_q == ST_LOAD);

  sha512_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(core_start),
    .blk_i  (load_blk),
    .hash_i (hash_q),
    .done_o (core_done),
    .vars_o (core_vars)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pend_n_q    <= '0;
      last_q      <= 1'b0;
      fin_q       <= 1'b0;
      extra_q     <= 1'b0;
      len_en_q    <= 1'b0;
      zero_from_q <= 5'd16;
      out_idx_q   <= '0;
      hash_q      <= h_init();
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pend_n_q <= (s_axis_tdata_i[67:64] > 4'd8) ? 4'd8 : s_axis_tdata_i[67:64];
            last_q   <= s_axis_tlast_i;
            state_q  <= ST_ABSORB;
          end
        end
        ST_ABSORB: begin
          if (pend_n_q == 4'd0) begin
            state_q <= last_q ? ST_PAD : ST_IDLE;
          end else begin
            cnt_q    <= cnt_q + {124'd0, n1};
            pend_n_q <= pend_n_q - n1;
            if (pos_next == 7'd0) begin
              zero_from_q <= 5'd16;
              len_en_q    <= 1'b0;
              fin_q       <= 1'b0;
              extra_q     <= 1'b0;
              state_q     <= ST_LOAD;
            end
          end
        end
        ST_PAD: begin
          zero_from_q <= {1'b0, wi} + 5'd1;
          if (cnt_q[6:0] >= 7'd112) begin
            len_en_q <= 1'b0;
            fin_q    <= 1'b0;
            extra_q  <= 1'b1;
          end else begin
            len_en_q <= 1'b1;
            fin_q    <= 1'b1;
            extra_q  <= 1'b0;
          end
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (core_done) begin
            for (int i = 0; i < 8; i++) begin
              hash_q[i] <= hash_q[i] + core_vars[i];
            end
            if (fin_q) begin
              out_idx_q <= '0;
              state_q   <= ST_OUT;
            end else if (extra_q) begin
              extra_q     <= 1'b0;
              fin_q       <= 1'b1;
              len_en_q    <= 1'b1;
              zero_from_q <= 5'd0;
              state_q     <= ST_LOAD;
            end else begin
              state_q <= ST_ABSORB;
            end
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            out_idx_q <= out_idx_q + 1'b1;
            if (out_idx_q == 3'd7) begin
              hash_q  <= h_init();
              cnt_q   <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= s_axis_tdata_i[63:0];
    end else if (state_q == ST_ABSORB && pend_n_q != 4'd0) begin
      blk_q[wi] <= (blk_q[wi] & ~wmask) | (wdata & wmask);
      pend_q    <= pend_q << {n1, 3'b000};
    end else if (state_q == ST_PAD) begin
      blk_q[wi] <= (blk_q[wi] & keep) | (64'h8000_0000_0000_0000 >> {off, 3'b000});
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = hash_q[out_idx_q];
  assign m_axis_tlast_o  = (out_idx_q == 3'd7);

  `SHA_NEVER(a_in_out_excl, s_axis_tready_o && m_axis_tvalid_o, "input ready during output")
  `SHA_NEVER(a_pend_range, pend_n_q > 4'd8, "pending byte count above eight")
  `SHA_ASSERT(a_clear_after, (out_acc && m_axis_tlast_o) |=> cnt_q == '0, "count not cleared")
  `SHA_ASSERT(a_start_idle, core_start |=> !core_done, "core done right after start")

endmodule
